[rtl/typed_stack_allocator_macros.svh]
// Assertion macros used by the typed stack allocator top level.
`ifndef TYPED_STACK_ALLOCATOR_MACROS_SVH
`define TYPED_STACK_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define TSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define TSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/tsa_pkg.sv]
// Shared types and constants of the typed stack allocator.
`default_nettype none

package tsa_pkg;

    localparam int MAX_CHUNKS = 256;
    localparam int IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

    localparam int POOL_W     = 24;
    localparam int SIZE_W     = 16;
    localparam int TYPE_W     = 4;
    localparam int OUT_CNT_W  = 9;

    localparam logic [POOL_W-1:0] POOL_RESET = 24'd262144;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_BYTES   = 2'd1,
        STAT_TABLE_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_POP,
        FSM_RESULT
    } t_fsm;

    typedef struct packed {
        t_opcode             opcode;
        logic [SIZE_W-1:0]   chunk_size;
        logic [TYPE_W-1:0]   chunk_type;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [POOL_W-1:0]    offset;
        logic [OUT_CNT_W-1:0] freed_chunks;
        logic [POOL_W-1:0]    used_after;
        logic [OUT_CNT_W-1:0] chunks_after;
    } t_rsp;

    // One chunk table entry: its type tag and its byte count.
    typedef struct packed {
        logic [TYPE_W-1:0] chunk_type;
        logic [SIZE_W-1:0] chunk_size;
    } t_entry;

endpackage

`default_nettype wire

[rtl/typed_stack_allocator.sv]
// Top level of the typed stack allocator: control, counters and result register.
// Sequence: an accepted push or empty-stack pop goes to the result state, from which its result is loaded
// into the output register; any other pop first walks the stack in the pop state, freeing matching
// top chunks until a type mismatch or the last chunk ends the walk. A new request is taken
// only once the previous result has moved into the output register, so a full output register holds it up.
// Reset (synchronous, active low) empties the stack and sets the pool to 262144 bytes.
`default_nettype none

`include "typed_stack_allocator_macros.svh"

module typed_stack_allocator
    import tsa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Configuration write channel: total pool size in bytes.
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [POOL_W-1:0] i_cfg_data,
    // Request channel.
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_req              i_in_req,
    // Result channel.
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_rsp                   o_out_rsp
);

    // Control state and counters.
    t_fsm              r_state, n_state;
    logic [POOL_W-1:0] r_pool;
    logic [POOL_W-1:0] r_used, n_used;
    logic [CNT_W-1:0]  r_count, n_count;

    // Working registers of the request in flight.
    logic [TYPE_W-1:0] r_type, n_type;
    logic [CNT_W-1:0]  r_freed, n_freed;
    t_status           r_status, n_status;
    logic [POOL_W-1:0] r_offset, n_offset;

    // Output register.
    logic              r_out_valid;
    t_rsp              r_out;

    // Chunk table port signals.
    logic              w_we;
    logic              w_re;
    logic [IDX_W-1:0]  w_raddr;
    t_entry            w_wdata;
    t_entry            w_rdata;

    logic              w_in_fire;
    logic              w_out_load;
    logic              w_hit;
    logic              w_push_ok;
    logic [POOL_W:0]   w_sum;
    logic [IDX_W-1:0]  w_top_idx;
    logic [IDX_W-1:0]  w_below_idx;

    // The configuration register is always writable; the user must write only while idle (not enforced).
    assign o_cfg_ready = 1'b1;

    // Requests are taken only when no earlier request is still being worked on.
    // A finished result may still sit in the output register at that time.
    assign o_in_ready  = (r_state == FSM_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;

    // The result moves out once the output register is free or being emptied.
    assign w_out_load  = (r_state == FSM_RESULT) && (!r_out_valid || i_out_ready);

    // A push fits when the new top stays within the pool and the table has room; the sum is one bit wider.
    assign w_sum       = {1'b0, r_used} + (POOL_W + 1)'(i_in_req.chunk_size);
    assign w_push_ok   = (w_sum <= {1'b0, r_pool}) && (r_count < CNT_W'(MAX_CHUNKS));

    // Index of the top chunk and of the one just below it.
    assign w_top_idx   = IDX_W'(r_count - CNT_W'(1));
    assign w_below_idx = IDX_W'(r_count - CNT_W'(2));

    // During a pop walk the read data holds the entry at the current top.
    assign w_hit       = (w_rdata.chunk_type == r_type);

    tsa_chunk_ram u_chunk_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IDX_W'(r_count)),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_IDLE: begin
                if (w_in_fire) begin
                    if (i_in_req.opcode == OP_PUSH || r_count == '0) begin
                        n_state = FSM_RESULT;
                    end else begin
                        n_state = FSM_POP;
                    end
                end
            end
            FSM_POP: begin
                // Stop on the first mismatch, or after freeing the last chunk.
                if (!w_hit || r_count == CNT_W'(1)) begin
                    n_state = FSM_RESULT;
                end
            end
            FSM_RESULT: begin
                if (w_out_load) begin
                    n_state = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_used   = r_used;
        n_count  = r_count;
        n_type   = r_type;
        n_freed  = r_freed;
        n_status = r_status;
        n_offset = r_offset;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_raddr  = w_top_idx;
        w_wdata.chunk_type = i_in_req.chunk_type;
        w_wdata.chunk_size = i_in_req.chunk_size;
        case (r_state)
            FSM_IDLE: begin
                if (w_in_fire) begin
                    n_type   = i_in_req.chunk_type;
                    n_freed  = '0;
                    n_offset = '0;
                    n_status = STAT_OK;
                    if (i_in_req.opcode == OP_PUSH) begin
                        // The byte check takes priority over the table check.
                        if (w_sum > {1'b0, r_pool}) begin
                            n_status = STAT_NO_BYTES;
                        end else if (r_count >= CNT_W'(MAX_CHUNKS)) begin
                            n_status = STAT_TABLE_FULL;
                        end else begin
                            w_we     = 1'b1;
                            n_offset = r_used;
                            n_used   = w_sum[POOL_W-1:0];
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else if (r_count != '0) begin
                        // Fetch the top entry; it is compared in the next cycle.
                        w_re = 1'b1;
                    end
                end
            end
            FSM_POP: begin
                if (w_hit) begin
                    n_count = r_count - CNT_W'(1);
                    n_used  = r_used - POOL_W'(w_rdata.chunk_size);
                    n_freed = r_freed + CNT_W'(1);
                    // The entry below becomes the new top; fetch it right away.
                    // When the stack runs empty this read is simply unused.
                    w_re    = 1'b1;
                    w_raddr = w_below_idx;
                end
            end
            FSM_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
            r_pool  <= POOL_RESET;
            r_used  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pool <= i_cfg_data;
            end
        end
    end

    // Working registers of the request carry no reset; they are set on acceptance.
    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_freed  <= n_freed;
        r_status <= n_status;
        r_offset <= n_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.status       <= r_status;
            r_out.offset       <= r_offset;
            r_out.freed_chunks <= OUT_CNT_W'(r_freed);
            r_out.used_after   <= r_used;
            r_out.chunks_after <= OUT_CNT_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // A pop walk only runs while chunks remain on the stack.
    `TSA_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, r_state == FSM_POP, r_count != '0, "pop walk on empty stack")

    // Each matching top chunk frees exactly one chunk.
    `TSA_ASSERT_NEXT(a_pop_step, i_clk, i_rst_n, r_state == FSM_POP && w_hit, r_freed == $past(r_freed) + CNT_W'(1) && r_count == $past(r_count) - CNT_W'(1), "pop step miscounted")

    // An accepted push that fits grows the stack by one chunk.
    `TSA_ASSERT_NEXT(a_push_grow, i_clk, i_rst_n, w_in_fire && i_in_req.opcode == OP_PUSH && w_push_ok, r_count == $past(r_count) + CNT_W'(1) && r_status == STAT_OK, "push did not grow stack")

endmodule

`default_nettype wire

[rtl/tsa_chunk_ram.sv]
// Chunk table memory: one write port, one read port, registered read data.
`default_nettype none

module tsa_chunk_ram
    import tsa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_entry           i_wdata,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);

    t_entry r_mem [MAX_CHUNKS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[test/typed_stack_allocator_test.sv]
// Self-checking testbench for the typed stack allocator: directed and random push/pop traffic.
`timescale 1ns / 1ps

module typed_stack_allocator_test
    import tsa_pkg::*;
();

    // Minimum number of random requests issued after the directed part.
    localparam int unsigned RANDOM_ITEMS = 1950;

    // Shadow copy of the allocator. It replays every accepted request on its own stack
    // and byte counters, keeps the responses they must produce in order, and compares
    // each response that leaves the block against the oldest one.
    class stack_shadow;
        logic [SIZE_W-1:0] size_tab [MAX_CHUNKS];
        logic [TYPE_W-1:0] type_tab [MAX_CHUNKS];
        logic [POOL_W-1:0] used_bytes;
        logic [POOL_W-1:0] pool_bytes;
        logic [CNT_W-1:0]  chunk_cnt;
        t_rsp              expected_rsps [$];
        int unsigned       errors;

        function new();
            used_bytes = '0;
            pool_bytes = POOL_RESET;
            chunk_cnt  = '0;
            errors     = 0;
        endfunction

        function void set_pool(logic [POOL_W-1:0] bytes);
            pool_bytes = bytes;
        endfunction

        // Type tag of the chunk on top of the stack, or any tag when it is empty.
        function logic [TYPE_W-1:0] top_type();
            if (chunk_cnt == 0) begin
                return TYPE_W'($urandom);
            end
            return type_tab[chunk_cnt - 1];
        endfunction

        function string rsp_text(t_rsp r);
            return $sformatf("status=%0d offset=%0d freed=%0d used=%0d chunks=%0d",
                             r.status, r.offset, r.freed_chunks, r.used_after, r.chunks_after);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endfunction

        // Works out the response to one accepted request and queues it.
        function void note_request(t_req r);
            t_rsp rsp;
            rsp = '0;
            rsp.status = STAT_OK;
            if (r.opcode == OP_PUSH) begin
                // The byte check wins over the table check when both limits are hit.
                if (({1'b0, used_bytes} + (POOL_W + 1)'(r.chunk_size)) > {1'b0, pool_bytes}) begin
                    rsp.status = STAT_NO_BYTES;
                end else if (chunk_cnt >= CNT_W'(MAX_CHUNKS)) begin
                    rsp.status = STAT_TABLE_FULL;
                end else begin
                    size_tab[chunk_cnt] = r.chunk_size;
                    type_tab[chunk_cnt] = r.chunk_type;
                    rsp.offset = used_bytes;
                    used_bytes = used_bytes + POOL_W'(r.chunk_size);
                    chunk_cnt  = chunk_cnt + 1'b1;
                end
            end else begin
                while (chunk_cnt != 0 && type_tab[chunk_cnt - 1] == r.chunk_type) begin
                    chunk_cnt  = chunk_cnt - 1'b1;
                    used_bytes = used_bytes - POOL_W'(size_tab[chunk_cnt]);
                    rsp.freed_chunks = rsp.freed_chunks + 1'b1;
                end
            end
            rsp.used_after   = used_bytes;
            rsp.chunks_after = OUT_CNT_W'(chunk_cnt);
            expected_rsps.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsps.size() == 0) begin
                flag({"response with none outstanding: ", rsp_text(got)});
                return;
            end
            want = expected_rsps.pop_front();
            if (got.status !== want.status || got.offset !== want.offset ||
                got.freed_chunks !== want.freed_chunks || got.used_after !== want.used_after ||
                got.chunks_after !== want.chunks_after) begin
                flag({"expected ", rsp_text(want), " got ", rsp_text(got)});
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [POOL_W-1:0] i_cfg_data = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_req        i_in_req    = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_rsp        o_out_rsp;

    stack_shadow shadow;

    // Sender pacing: requests go out in bursts, separated by idle gaps.
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;

    // Receiver pacing: the stall pattern switches between a few modes over time.
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;
    int unsigned rx_tick = 0;
    int unsigned rx_run  = 0;
    bit          rx_hold = 1'b1;

    typed_stack_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Response side. Signals are sampled at the rising edge before any of this edge's
    // updates land, so the handshake seen here is the one the block sees. Ready then
    // gets its next value from the current stall mode: always ready, coin flips, one
    // cycle in four, or alternating runs of stall and ready of random length.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            shadow.check_response(o_out_rsp);
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(32, 256);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_out_ready <= (rx_tick % 4 == 0);
            end
            default: begin
                if (rx_run == 0) begin
                    rx_hold = ~rx_hold;
                    rx_run  = $urandom_range(1, 24);
                end
                rx_run--;
                i_out_ready <= rx_hold;
            end
        endcase
    end

    function automatic t_req make_req(t_opcode op, logic [SIZE_W-1:0] sz,
                                      logic [TYPE_W-1:0] ty);
        t_req r;
        r.opcode     = op;
        r.chunk_size = sz;
        r.chunk_type = ty;
        return r;
    endfunction

    // Push sizes: mostly small enough that a good share of pushes fit the current pool,
    // with the zero size, the largest size and full-range values mixed in.
    function automatic logic [SIZE_W-1:0] gen_size();
        int unsigned cap;
        int unsigned pick;
        cap = shadow.pool_bytes / 64;
        if (cap > 65535) begin
            cap = 65535;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end
        if (pick == 1) begin
            return '1;
        end
        if (pick <= 3) begin
            return SIZE_W'($urandom);
        end
        return SIZE_W'($urandom_range(0, cap));
    endfunction

    // Pool sizes: both extremes, the reset value, random values, values at or above the bytes in
    // use, and values below them so that every push gets refused for lack of bytes.
    function automatic logic [POOL_W-1:0] pick_pool();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return POOL_RESET;
            end
            3: begin
                return POOL_W'($urandom);
            end
            4: begin
                return POOL_W'($urandom_range(0, 70000));
            end
            5: begin
                if (shadow.used_bytes == 0) begin
                    return '0;
                end
                return POOL_W'($urandom_range(0, shadow.used_bytes - 1));
            end
            default: begin
                return POOL_W'($urandom_range(shadow.used_bytes, 24'hFFFFFF));
            end
        endcase
    endfunction

    // Issues one request and returns at the edge where it is accepted. Valid is left
    // high so that the next request of the same burst follows without a bubble; it is
    // only lowered when a gap starts or the caller lowers it.
    task automatic send_req(input t_req r);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 16);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        shadow.note_request(r);
        items_sent++;
        burst_left--;
    endtask

    // Pool size writes happen only with the block idle: no request pending and every
    // outstanding response delivered. At least one edge passes before the write, so
    // valid drops between back-to-back writes.
    task automatic write_pool(input logic [POOL_W-1:0] bytes);
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (shadow.expected_rsps.size() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bytes;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow.set_pool(bytes);
        burst_left = 0;
    endtask

    // Short directed sequence: empty pops, zero-size push, exact fill of the reset pool,
    // a push one byte too large, pops that match nothing, one, or several chunks, and
    // pool sizes of zero, below the bytes in use, and the maximum.
    task automatic run_directed();
        send_req(make_req(OP_POP, '1, 4'd5));
        send_req(make_req(OP_PUSH, '0, 4'd0));
        repeat (4) send_req(make_req(OP_PUSH, 16'hFFFF, 4'd15));
        send_req(make_req(OP_PUSH, 16'd5, 4'd1));
        send_req(make_req(OP_PUSH, 16'd4, 4'd15));
        send_req(make_req(OP_POP, '0, 4'd3));
        send_req(make_req(OP_POP, '0, 4'd15));
        send_req(make_req(OP_POP, '0, 4'd0));
        send_req(make_req(OP_PUSH, 16'd1000, 4'd2));
        send_req(make_req(OP_PUSH, 16'd24, 4'd10));
        write_pool(24'd500);
        send_req(make_req(OP_PUSH, '0, 4'd2));
        send_req(make_req(OP_POP, 16'h5A5A, 4'd10));
        send_req(make_req(OP_POP, '0, 4'd2));
        write_pool('0);
        send_req(make_req(OP_PUSH, '0, 4'd9));
        send_req(make_req(OP_PUSH, 16'd1, 4'd9));
        send_req(make_req(OP_POP, '0, 4'd9));
        write_pool('1);
        send_req(make_req(OP_PUSH, 16'hFFFF, 4'd6));
        send_req(make_req(OP_POP, '0, 4'd6));
    endtask

    // Mixed traffic over a few neighboring type tags, so pops often strip several
    // chunks. Most pops name the type on top of the stack; the rest use any type.
    task automatic churn(input int unsigned n);
        logic [TYPE_W-1:0] base;
        int unsigned k;
        int unsigned push_pct;
        base = TYPE_W'($urandom);
        for (k = 0; k < n; k++) begin
            push_pct = (shadow.chunk_cnt > 200) ? 35 : 65;
            if ($urandom_range(0, 99) < push_pct) begin
                send_req(make_req(OP_PUSH, gen_size(), base + TYPE_W'($urandom_range(0, 2))));
            end else if ($urandom_range(0, 9) < 7) begin
                send_req(make_req(OP_POP, SIZE_W'($urandom), shadow.top_type()));
            end else begin
                send_req(make_req(OP_POP, SIZE_W'($urandom), TYPE_W'($urandom)));
            end
        end
    endtask

    // Sizes the pool so that the table fills up before the bytes run out, fills it,
    // then pushes on past the end. Large extra pushes also overrun the few bytes left,
    // which covers the case where both limits are exceeded at once.
    task automatic fill_table();
        int unsigned smax;
        int unsigned room;
        int unsigned tries;
        int unsigned extra;
        int unsigned k;
        case ($urandom_range(0, 3))
            0: smax = 0;
            1: smax = 15;
            2: smax = 255;
            default: smax = 65535;
        endcase
        room = shadow.used_bytes + 256 * smax + $urandom_range(0, smax);
        write_pool((room > 24'hFFFFFF) ? 24'hFFFFFF : POOL_W'(room));
        for (tries = 0; shadow.chunk_cnt < MAX_CHUNKS && tries < 600; tries++) begin
            send_req(make_req(OP_PUSH, SIZE_W'($urandom_range(0, smax)), TYPE_W'($urandom)));
        end
        extra = $urandom_range(3, 8);
        for (k = 0; k < extra; k++) begin
            case ($urandom_range(0, 2))
                0: send_req(make_req(OP_PUSH, '0, TYPE_W'($urandom)));
                1: send_req(make_req(OP_PUSH, '1, TYPE_W'($urandom)));
                default: send_req(make_req(OP_PUSH, SIZE_W'($urandom), TYPE_W'($urandom)));
            endcase
        end
    endtask

    // Empties the stack with pops of the top type, with a stray pop now and then.
    task automatic drain();
        int unsigned guard;
        for (guard = 0; shadow.chunk_cnt != 0 && guard < 300; guard++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_req(make_req(OP_POP, SIZE_W'($urandom), TYPE_W'($urandom)));
            end else begin
                send_req(make_req(OP_POP, SIZE_W'($urandom), shadow.top_type()));
            end
        end
    endtask

    task automatic run_random();
        int unsigned goal;
        int unsigned episode;
        goal = items_sent + RANDOM_ITEMS;
        for (episode = 0; items_sent < goal; episode++) begin
            if (episode % 3 == 0) begin
                write_pool(pick_pool());
            end
            case ($urandom_range(0, 9))
                0, 1: fill_table();
                8, 9: drain();
                default: churn($urandom_range(40, 160));
            endcase
        end
    endtask

    initial begin
        shadow = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        // Let every outstanding response drain, then keep the clock running so that any
        // response that should not be there still shows.
        i_in_valid <= 1'b0;
        while (shadow.expected_rsps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.expected_rsps.size() == 0) begin
            $display("[typed_stack_allocator] OK");
        end else begin
            $display("[typed_stack_allocator] ERROR");
        end
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial begin
        #10_000_000;
        $display("[typed_stack_allocator] ERROR");
        $finish;
    end

endmodule
